>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hsv_pkg.sv
`timescale 1ns / 1ps

package hsv_pkg;

    localparam int HUE_W     = 16;
    localparam int PCT_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int DEG_W     = 9;
    localparam int WGT_W     = 6;
    localparam int VS_W      = 14;
    localparam int TERM_W    = 20;
    localparam int SCALE_W   = 18;
    localparam int CH_W      = 8;
    localparam int NSTAGE    = 7;

    localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;
    localparam logic [VS_W-1:0]   VS_FULL   = 14'd10000;
    localparam logic [TERM_W-1:0] TERM_FULL = 20'd600000;
    localparam logic [TERM_W-1:0] DEG_SECTOR = 20'd60;
    localparam logic [TERM_W-1:0] VAL_SCALE  = 20'd6000;

    // hue / 360 as (hue * 46604) >> 24, exact for 16-bit hue
    localparam logic [HUE_W-1:0] RECIP_360    = 16'd46604;
    localparam int               RECIP_360_SH = 24;
    localparam logic [HUE_W-1:0] DEG_FULL     = 16'd360;

    // 255/600000 = 17/40000 = (17 / 64) / 625, and /625 as (n * 429497) >> 28
    localparam logic [23:0] SCALE_NUM    = 24'd17;
    localparam int          SCALE_PRE_SH = 6;
    localparam logic [18:0] RECIP_625    = 19'd429497;
    localparam int          RECIP_625_SH = 28;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SATURATION = 2'd0,
        CFG_BRIGHTNESS = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [VS_W-1:0]   vs;
        logic [TERM_W-1:0] chroma;
        logic [TERM_W-1:0] offset;
    } t_cfg_terms;

endpackage

>>> hdl/hsv_cfg.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsv_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hsv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hsv_pkg::PCT_W-1:0]     i_cfg_data,
    output hsv_pkg::t_cfg_terms           o_terms
);
    import hsv_pkg::*;

    logic [PCT_W-1:0]  r_sat, r_val, r_val_d;
    logic [PCT_W-1:0]  n_sat, n_val, w_clamped;
    logic [VS_W-1:0]   r_vs;
    logic [TERM_W-1:0] r_chroma, r_offset;
    logic [TERM_W-1:0] n_chroma, n_offset;

    assign w_clamped = (i_cfg_data > PCT_MAX) ? PCT_MAX : i_cfg_data;

    always_comb begin
        n_sat = r_sat;
        n_val = r_val;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SATURATION: n_sat = w_clamped;
                CFG_BRIGHTNESS: n_val = w_clamped;
                default: ;
            endcase
        end
    end

    // derived terms settle after a write: r_vs and r_val_d first, then r_chroma and r_offset
    assign n_chroma = TERM_W'(r_vs) * DEG_SECTOR;
    assign n_offset = TERM_W'(r_val_d) * VAL_SCALE - n_chroma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat    <= PCT_MAX;
            r_val    <= PCT_MAX;
            r_val_d  <= PCT_MAX;
            r_vs     <= VS_FULL;
            r_chroma <= TERM_FULL;
            r_offset <= '0;
        end else begin
            r_sat    <= n_sat;
            r_val    <= n_val;
            r_val_d  <= r_val;
            r_vs     <= VS_W'(r_sat) * VS_W'(r_val);
            r_chroma <= n_chroma;
            r_offset <= n_offset;
        end
    end

    assign o_terms.vs     = r_vs;
    assign o_terms.chroma = r_chroma;
    assign o_terms.offset = r_offset;

    `ASSERT_ALWAYS(a_sat_clamped, r_sat <= PCT_MAX, "saturation above 100")
    `ASSERT_ALWAYS(a_val_clamped, r_val <= PCT_MAX, "brightness above 100")
    `ASSERT_ALWAYS(a_vs_range, r_vs <= VS_FULL, "v*s above full scale")
    `ASSERT_ALWAYS(a_terms_sum, (21'(r_chroma) + 21'(r_offset)) <= 21'(TERM_FULL),
        "chroma plus offset exceeds full scale")

endmodule

>>> hdl/hsv_hue.sv
`timescale 1ns / 1ps

module hsv_hue (
    input  logic                       i_clk,
    input  logic [2:0]                 i_en,
    input  logic [hsv_pkg::HUE_W-1:0]  i_hue,
    output hsv_pkg::t_sector           o_sector,
    output logic [hsv_pkg::WGT_W-1:0]  o_weight
);
    import hsv_pkg::*;

    logic [2*HUE_W-1:0] w_prod;
    logic [7:0]         r_quot;
    logic [HUE_W-1:0]   r_hue;
    logic [HUE_W-1:0]   w_diff;
    logic [DEG_W-1:0]   r_deg;
    logic [6:0]         w_mod120;
    logic [5:0]         w_dist;
    t_sector            n_sector, r_sector;
    logic [WGT_W-1:0]   n_weight, r_weight;

    // quotient by reciprocal, no correction needed over the 16-bit range
    assign w_prod = (2*HUE_W)'(i_hue) * (2*HUE_W)'(RECIP_360);
    assign w_diff = r_hue - HUE_W'(r_quot) * DEG_FULL;

    always_comb begin
        if (r_deg < 9'd60) begin
            n_sector = SEC_RED_YEL;
        end else if (r_deg < 9'd120) begin
            n_sector = SEC_YEL_GRN;
        end else if (r_deg < 9'd180) begin
            n_sector = SEC_GRN_CYN;
        end else if (r_deg < 9'd240) begin
            n_sector = SEC_CYN_BLU;
        end else if (r_deg < 9'd300) begin
            n_sector = SEC_BLU_MAG;
        end else begin
            n_sector = SEC_MAG_RED;
        end

        if (r_deg >= 9'd240) begin
            w_mod120 = 7'(r_deg - 9'd240);
        end else if (r_deg >= 9'd120) begin
            w_mod120 = 7'(r_deg - 9'd120);
        end else begin
            w_mod120 = 7'(r_deg);
        end

        w_dist   = (w_mod120 >= 7'd60) ? 6'(w_mod120 - 7'd60) : 6'(7'd60 - w_mod120);
        n_weight = WGT_W'(6'd60 - w_dist);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_quot <= w_prod[RECIP_360_SH +: 8];
            r_hue  <= i_hue;
        end
        if (i_en[1]) begin
            r_deg <= w_diff[DEG_W-1:0];
        end
        if (i_en[2]) begin
            r_sector <= n_sector;
            r_weight <= n_weight;
        end
    end

    assign o_sector = r_sector;
    assign o_weight = r_weight;

endmodule

>>> hdl/hsv_mix.sv
`timescale 1ns / 1ps

module hsv_mix (
    input  logic                       i_clk,
    input  logic [1:0]                 i_en,
    input  hsv_pkg::t_cfg_terms        i_terms,
    input  hsv_pkg::t_sector           i_sector,
    input  logic [hsv_pkg::WGT_W-1:0]  i_weight,
    output logic [hsv_pkg::TERM_W-1:0] o_sum_green,
    output logic [hsv_pkg::TERM_W-1:0] o_sum_red,
    output logic [hsv_pkg::TERM_W-1:0] o_sum_blue
);
    import hsv_pkg::*;

    logic [TERM_W-1:0] r_x;
    t_sector           r_sector;
    logic [TERM_W-1:0] w_r, w_g, w_b;
    logic [TERM_W-1:0] n_sum_green, n_sum_red, n_sum_blue;
    logic [TERM_W-1:0] r_sum_green, r_sum_red, r_sum_blue;

    always_comb begin
        unique case (r_sector)
            SEC_RED_YEL: begin
                w_r = i_terms.chroma; w_g = r_x;            w_b = '0;
            end
            SEC_YEL_GRN: begin
                w_r = r_x;            w_g = i_terms.chroma; w_b = '0;
            end
            SEC_GRN_CYN: begin
                w_r = '0;             w_g = i_terms.chroma; w_b = r_x;
            end
            SEC_CYN_BLU: begin
                w_r = '0;             w_g = r_x;            w_b = i_terms.chroma;
            end
            SEC_BLU_MAG: begin
                w_r = r_x;            w_g = '0;             w_b = i_terms.chroma;
            end
            SEC_MAG_RED: begin
                w_r = i_terms.chroma; w_g = '0;             w_b = r_x;
            end
            default: begin
                w_r = '0;             w_g = '0;             w_b = '0;
            end
        endcase
        n_sum_green = w_g + i_terms.offset;
        n_sum_red   = w_r + i_terms.offset;
        n_sum_blue  = w_b + i_terms.offset;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x      <= TERM_W'(i_terms.vs) * TERM_W'(i_weight);
            r_sector <= i_sector;
        end
        if (i_en[1]) begin
            r_sum_green <= n_sum_green;
            r_sum_red   <= n_sum_red;
            r_sum_blue  <= n_sum_blue;
        end
    end

    assign o_sum_green = r_sum_green;
    assign o_sum_red   = r_sum_red;
    assign o_sum_blue  = r_sum_blue;

endmodule

>>> hdl/hsv_scale.sv
`timescale 1ns / 1ps

module hsv_scale (
    input  logic                       i_clk,
    input  logic [1:0]                 i_en,
    input  logic [hsv_pkg::TERM_W-1:0] i_sum,
    output logic [hsv_pkg::CH_W-1:0]   o_byte
);
    import hsv_pkg::*;

    logic [23:0]        w_mul17;
    logic [SCALE_W-1:0] r_scaled;
    logic [36:0]        w_prod;
    logic [CH_W-1:0]    r_byte;

    // floor(sum*255/600000) = floor(floor(sum*17 / 64) / 625)
    assign w_mul17 = 24'(i_sum) * SCALE_NUM;
    assign w_prod  = 37'(r_scaled) * 37'(RECIP_625);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_scaled <= w_mul17[SCALE_PRE_SH +: SCALE_W];
        end
        if (i_en[1]) begin
            r_byte <= w_prod[RECIP_625_SH +: CH_W];
        end
    end

    assign o_byte = r_byte;

endmodule

>>> hdl/hsv_to_rgb_pixel_converter.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// throughput: one pixel per cycle while the output accepts results
// stages: hue reciprocal, mod 360, sector and weight, v*s*weight, offset add, two scale steps
// a stalled output holds only the stages behind it that are full; bubbles are squeezed out
// reset (synchronous, active low) empties the pipeline and sets saturation and brightness to 100
module hsv_to_rgb_pixel_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [hsv_pkg::HUE_W-1:0]     i_hue,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [hsv_pkg::CH_W-1:0]      o_green,
    output logic [hsv_pkg::CH_W-1:0]      o_red,
    output logic [hsv_pkg::CH_W-1:0]      o_blue,
    input  logic                          i_cfg_we,
    input  logic [hsv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hsv_pkg::PCT_W-1:0]     i_cfg_data
);
    import hsv_pkg::*;

    logic [NSTAGE-1:0] r_vld, n_vld, w_adv;
    t_cfg_terms        w_terms;
    t_sector           w_sector;
    logic [WGT_W-1:0]  w_weight;
    logic [TERM_W-1:0] w_sum_green, w_sum_red, w_sum_blue;

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_adv[NSTAGE-1] = !r_vld[NSTAGE-1] || i_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
        n_vld = r_vld;
        if (w_adv[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (w_adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NSTAGE-1];

    hsv_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_terms    (w_terms)
    );

    hsv_hue u_hue (
        .i_clk    (i_clk),
        .i_en     (w_adv[2:0]),
        .i_hue    (i_hue),
        .o_sector (w_sector),
        .o_weight (w_weight)
    );

    hsv_mix u_mix (
        .i_clk       (i_clk),
        .i_en        (w_adv[4:3]),
        .i_terms     (w_terms),
        .i_sector    (w_sector),
        .i_weight    (w_weight),
        .o_sum_green (w_sum_green),
        .o_sum_red   (w_sum_red),
        .o_sum_blue  (w_sum_blue)
    );

    hsv_scale u_scale_green (
        .i_clk  (i_clk),
        .i_en   (w_adv[6:5]),
        .i_sum  (w_sum_green),
        .o_byte (o_green)
    );

    hsv_scale u_scale_red (
        .i_clk  (i_clk),
        .i_en   (w_adv[6:5]),
        .i_sum  (w_sum_red),
        .o_byte (o_red)
    );

    hsv_scale u_scale_blue (
        .i_clk  (i_clk),
        .i_en   (w_adv[6:5]),
        .i_sum  (w_sum_blue),
        .o_byte (o_blue)
    );

    `ASSERT_IMPLY(a_full_when_blocked, !o_ready, &r_vld, "input blocked with a free stage")
    `ASSERT_NEXT(a_transfer_enters, i_valid && o_ready, r_vld[0], "accepted pixel lost")
    `ASSERT_NEXT(a_output_held, o_valid && !i_ready,
        o_valid && $stable(o_green) && $stable(o_red) && $stable(o_blue), "result changed in stall")

endmodule

>>> bench/hsv_to_rgb_pixel_converter_tb.sv
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_converter_tb;
    import hsv_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int PIPE_DEPTH  = 7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_REPORTS = 10;

    // indexes past the last register, writes to them are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] blue;
    } t_rgb_pixel;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [HUE_W-1:0]     i_hue;
    logic                 o_valid;
    logic                 i_ready;
    logic [CH_W-1:0]      o_green;
    logic [CH_W-1:0]      o_red;
    logic [CH_W-1:0]      o_blue;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [PCT_W-1:0]     i_cfg_data;

    hsv_to_rgb_pixel_converter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_hue      (i_hue),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_green    (o_green),
        .o_red      (o_red),
        .o_blue     (o_blue),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // local copy of the two percentage registers
    int unsigned sat_pct;
    int unsigned bri_pct;

    t_rgb_pixel pending_pixels[$];
    int         err_count;
    int         cycle_count;

    bit gaps_enable;
    bit stall_enable;
    bit hold_request;
    int hold_left;
    int ready_burst;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hsv_to_rgb_pixel_converter_tb failed");
            $finish;
        end
    end

    function automatic int unsigned clamp_pct(input logic [PCT_W-1:0] raw);
        return (raw > PCT_MAX) ? int'(PCT_MAX) : int'(raw);
    endfunction

    function automatic logic [CH_W-1:0] scale_channel(input int unsigned scaled);
        longint unsigned prod;
        prod = longint'(scaled) * 255;
        return CH_W'(prod / 600000);
    endfunction

    function automatic t_rgb_pixel convert_hue(input logic [HUE_W-1:0] hue_in);
        int unsigned h, vs, chroma, t, fold, x, m, r, g, b;
        t_rgb_pixel  px;
        h      = hue_in % 360;
        vs     = bri_pct * sat_pct;
        chroma = 60 * vs;
        t      = h % 120;
        fold   = (t >= 60) ? t - 60 : 60 - t;
        x      = vs * (60 - fold);
        m      = 6000 * bri_pct - 60 * vs;
        // sector edges go to the upper sector
        if (h < 60) begin
            r = chroma; g = x; b = 0;
        end else if (h < 120) begin
            r = x; g = chroma; b = 0;
        end else if (h < 180) begin
            r = 0; g = chroma; b = x;
        end else if (h < 240) begin
            r = 0; g = x; b = chroma;
        end else if (h < 300) begin
            r = x; g = 0; b = chroma;
        end else begin
            r = chroma; g = 0; b = x;
        end
        px.green = scale_channel(g + m);
        px.red   = scale_channel(r + m);
        px.blue  = scale_channel(b + m);
        return px;
    endfunction

    // input transfers queue a prediction, output transfers are checked against the oldest
    always @(posedge i_clk) begin
        t_rgb_pixel want;
        t_rgb_pixel got;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                pending_pixels.push_back(convert_hue(i_hue));
            if (o_valid && i_ready) begin
                got = '{green: o_green, red: o_red, blue: o_blue};
                if (pending_pixels.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected pixel g=%0d r=%0d b=%0d",
                                 o_green, o_red, o_blue);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.green !== want.green || got.red !== want.red ||
                        got.blue !== want.blue) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display({"pixel mismatch: want g=%0d r=%0d b=%0d",
                                      " got g=%0d r=%0d b=%0d"},
                                     want.green, want.red, want.blue,
                                     got.green, got.red, got.blue);
                    end
                end
            end
        end
    end

    // output side ready: random bursts, plus one long hold-off on request
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                i_ready <= 1'b0;
            end else if (!stall_enable) begin
                i_ready <= 1'b1;
            end else if (ready_burst > 0) begin
                ready_burst--;
            end else begin
                ready_burst = $urandom_range(1, 9) - 1;
                i_ready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    task automatic send_hue(input logic [HUE_W-1:0] hue_val);
        int gap;
        if (gaps_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_hue   <= hue_val;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PCT_W-1:0] data);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SATURATION)
            sat_pct = clamp_pct(data);
        else if (idx == CFG_BRIGHTNESS)
            bri_pct = clamp_pct(data);
    endtask

    function automatic logic [HUE_W-1:0] random_hue();
        int unsigned h;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: h = $urandom_range(0, 359);
            4, 5: begin
                // around a sector edge, sometimes wrapped by whole turns
                h = $urandom_range(0, 6) * 60 + $urandom_range(0, 2);
                if (h > 0)
                    h = h - 1;
                if ($urandom_range(0, 1) == 1)
                    h = h + 360 * $urandom_range(0, 180);
            end
            default: h = $urandom_range(0, 65535);
        endcase
        return HUE_W'(h);
    endfunction

    function automatic logic [PCT_W-1:0] random_pct();
        case ($urandom_range(0, 5))
            0: return 7'd0;
            1: return PCT_MAX;
            2: return 7'd127;
            3: return 7'd101;
            default: return PCT_W'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic test_reset_defaults();
        logic [HUE_W-1:0] hues[$];
        hues = '{16'd0, 16'd1, 16'd59, 16'd60, 16'd119, 16'd120, 16'd179, 16'd180,
                 16'd239, 16'd240, 16'd299, 16'd300, 16'd359, 16'd360, 16'd65535};
        foreach (hues[i]) send_hue(hues[i]);
    endtask

    task automatic test_register_writes();
        write_reg(CFG_SATURATION, 7'd127);
        write_reg(CFG_BRIGHTNESS, 7'd101);
        send_hue(16'd30);
        send_hue(16'd200);
        // dropped writes must leave both registers alone
        write_reg(CFG_IDX_SPARE_A, 7'd0);
        write_reg(CFG_IDX_SPARE_B, 7'd55);
        send_hue(16'd90);
        write_reg(CFG_SATURATION, 7'd0);
        send_hue(16'd150);
        send_hue(16'd330);
        write_reg(CFG_BRIGHTNESS, 7'd0);
        send_hue(16'd270);
        write_reg(CFG_SATURATION, 7'd100);
        write_reg(CFG_BRIGHTNESS, 7'd50);
        send_hue(16'd45);
        send_hue(16'd65534);
    endtask

    task automatic test_random_hues();
        for (int phase = 0; phase < 10; phase++) begin
            write_reg(CFG_SATURATION, random_pct());
            write_reg(CFG_BRIGHTNESS, random_pct());
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                          PCT_W'($urandom_range(0, 127)));
            for (int n = 0; n < 120; n++) send_hue(random_hue());
        end
    endtask

    task automatic test_backpressure();
        write_reg(CFG_SATURATION, PCT_W'($urandom_range(0, 100)));
        write_reg(CFG_BRIGHTNESS, PCT_W'($urandom_range(0, 100)));
        gaps_enable  = 1'b0;
        hold_request = 1'b1;
        for (int n = 0; n < 40; n++) send_hue(random_hue());
        gaps_enable = 1'b1;
    endtask

    task automatic test_streaming();
        write_reg(CFG_SATURATION, PCT_MAX);
        write_reg(CFG_BRIGHTNESS, PCT_MAX);
        gaps_enable  = 1'b0;
        stall_enable = 1'b0;
        for (int n = 0; n < 60; n++) send_hue(random_hue());
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_hue      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_SATURATION;
        i_cfg_data <= '0;
        sat_pct      = 100;
        bri_pct      = 100;
        err_count    = 0;
        cycle_count  = 0;
        gaps_enable  = 1'b1;
        stall_enable = 1'b1;
        hold_request = 1'b0;
        hold_left    = 0;
        ready_burst  = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_writes();
        test_random_hues();
        test_backpressure();
        test_streaming();

        wait_drained();
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        if (err_count == 0 && pending_pixels.size() == 0)
            $display("hsv_to_rgb_pixel_converter_tb passed");
        else
            $display("hsv_to_rgb_pixel_converter_tb failed");
        $finish;
    end

endmodule
